FILE: rtl/stxrx_pkg.sv
// Shared types, constants and codes for the STX/ETX frame receiver.
package stxrx_pkg;

  localparam int MAX_FRAME_BYTES = 20;
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int IDX_W = $clog2(MAX_FRAME_BYTES);
  localparam int HEADER_BYTES = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] FRAME_START = 8'h02;
  localparam logic [7:0] FRAME_STOP = 8'h03;
  localparam logic [7:0] TIMEOUT_RESET = 8'd10;

  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_POLL = 2'd1;
  localparam logic [1:0] REQ_DOWN = 2'd2;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TIMEOUT = 2'd1;
  localparam logic [1:0] KIND_ACCEPT = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic [7:0] cmd_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] frame_byte;
    logic       last;
  } out_item_t;

  // Queue entry: KIND_BYTE streams count bytes, other kinds give one result.
  typedef struct packed {
    logic [1:0]       kind;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } store_wr_t;

  typedef struct packed {
    logic stream_done;
  } back_status_t;

endpackage

FILE: rtl/stxrx_front.sv
// Front end: deframer, reply timer and command classification.
module stxrx_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  stxrx_pkg::in_item_t  in_item,
  input  logic                 cfg_valid,
  input  logic [7:0]           cfg_data,
  input  logic                 q_full,
  output logic                 q_push,
  output stxrx_pkg::cmd_t      q_cmd,
  output stxrx_pkg::store_wr_t store_wr,
  input  stxrx_pkg::back_status_t back_status
);
  import stxrx_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_ADDR = 6'b000010,
    PH_CMD  = 6'b000100,
    PH_NBR  = 6'b001000,
    PH_DATA = 6'b010000,
    PH_END  = 6'b100000
  } phase_t;

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       data_count, data_count_next;
  logic             frame_done, frame_done_next;
  logic [7:0]       ticks_left, ticks_left_next;
  logic [7:0]       timeout_reg;
  logic             stream_busy, stream_busy_next;
  logic             accept;
  logic             wr_en;
  logic [CNT_W-1:0] wr_count;
  logic [CNT_W-1:0] count_after;
  logic [8:0]       data_end;
  logic [7:0]       b;

  assign in_stall = q_full || stream_busy;
  assign accept   = in_valid && !in_stall;
  assign b        = in_item.rx_byte;

  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    data_count_next  = data_count;
    frame_done_next  = frame_done;
    ticks_left_next  = ticks_left;
    stream_busy_next = stream_busy;
    wr_en            = 1'b0;
    wr_count         = byte_count;
    count_after      = byte_count;
    data_end         = 9'(HEADER_BYTES) + {1'b0, data_count};
    q_push           = 1'b0;
    q_cmd.kind       = KIND_BYTE;
    q_cmd.count      = byte_count;

    if (back_status.stream_done) begin
      stream_busy_next = 1'b0;
    end

    if (accept) begin
      case (in_item.req_type)
        REQ_BYTE: begin
          unique case (phase)
            PH_IDLE: begin
              if (b == FRAME_START) begin
                frame_done_next = 1'b0;
                wr_en           = 1'b1;
                wr_count        = '0;
                byte_count_next = CNT_W'(1);
                phase_next      = PH_ADDR;
              end
            end
            PH_ADDR: begin
              wr_en           = 1'b1;
              byte_count_next = byte_count + CNT_W'(1);
              phase_next      = PH_CMD;
            end
            PH_CMD: begin
              wr_en           = 1'b1;
              byte_count_next = byte_count + CNT_W'(1);
              phase_next      = PH_NBR;
            end
            PH_NBR: begin
              data_count_next = b;
              wr_en           = 1'b1;
              byte_count_next = byte_count + CNT_W'(1);
              phase_next      = (b != 8'd0) ? PH_DATA : PH_END;
            end
            PH_DATA: begin
              if (byte_count < CNT_W'(MAX_FRAME_BYTES - 1)) begin
                wr_en       = 1'b1;
                count_after = byte_count + CNT_W'(1);
              end
              byte_count_next = count_after;
              if (9'(count_after) >= data_end ||
                  count_after >= CNT_W'(MAX_FRAME_BYTES - 1)) begin
                phase_next = PH_END;
              end
            end
            PH_END: begin
              if (byte_count < CNT_W'(MAX_FRAME_BYTES)) begin
                wr_en           = 1'b1;
                byte_count_next = byte_count + CNT_W'(1);
              end
              if (b == FRAME_STOP) begin
                frame_done_next = 1'b1;
              end
              phase_next = PH_IDLE;
            end
            default: phase_next = PH_IDLE;
          endcase
        end
        REQ_POLL: begin
          if (frame_done) begin
            frame_done_next  = 1'b0;
            ticks_left_next  = 8'd0;
            stream_busy_next = 1'b1;
            q_push           = 1'b1;
            q_cmd.kind       = KIND_BYTE;
            q_cmd.count      = byte_count;
          end else if (ticks_left != 8'd0) begin
            ticks_left_next = ticks_left - 8'd1;
            if (ticks_left == 8'd1) begin
              q_push     = 1'b1;
              q_cmd.kind = KIND_TIMEOUT;
            end
          end
        end
        REQ_DOWN: begin
          q_push = 1'b1;
          if (in_item.cmd_length == 8'd0 ||
              in_item.cmd_length > 8'(MAX_FRAME_BYTES)) begin
            q_cmd.kind = KIND_REJECT;
          end else begin
            q_cmd.kind      = KIND_ACCEPT;
            ticks_left_next = timeout_reg;
          end
        end
        default: ;
      endcase
    end
  end

  // Store writes only happen for indices below the store depth.
  assign store_wr.en   = wr_en && (wr_count < CNT_W'(MAX_FRAME_BYTES));
  assign store_wr.idx  = IDX_W'(wr_count);
  assign store_wr.data = b;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      byte_count  <= '0;
      data_count  <= 8'd0;
      frame_done  <= 1'b0;
      ticks_left  <= 8'd0;
      timeout_reg <= TIMEOUT_RESET;
      stream_busy <= 1'b0;
    end else begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      data_count  <= data_count_next;
      frame_done  <= frame_done_next;
      ticks_left  <= ticks_left_next;
      stream_busy <= stream_busy_next;
      if (cfg_valid) begin
        timeout_reg <= cfg_data;
      end
    end
  end

endmodule

FILE: rtl/stxrx_queue.sv
// Small command queue between the front and back ends.
module stxrx_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  stxrx_pkg::cmd_t push_cmd,
  input  logic            pop,
  output stxrx_pkg::cmd_t pop_cmd,
  output logic            full,
  output logic            empty
);
  import stxrx_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   fill;

  assign full    = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign pop_cmd = entries[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop && !empty) begin
        rptr <= rptr + QPTR_W'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + (QPTR_W + 1)'(1);
        2'b01:   fill <= fill - (QPTR_W + 1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: rtl/stxrx_back.sv
// Back end: frame store, frame streaming and the output register.
module stxrx_back (
  input  logic                    clk,
  input  logic                    rst,
  input  stxrx_pkg::store_wr_t    store_wr,
  input  logic                    q_empty,
  input  stxrx_pkg::cmd_t         q_cmd,
  output logic                    q_pop,
  output stxrx_pkg::back_status_t back_status,
  output logic                    out_valid,
  input  logic                    out_stall,
  output stxrx_pkg::out_item_t    out_item
);
  import stxrx_pkg::*;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_READ = 3'b010,
    BK_SEND = 3'b100
  } bk_state_t;

  logic [7:0]       frame_store [MAX_FRAME_BYTES];
  bk_state_t        state, state_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [7:0]       rd_data;
  logic             out_free;
  logic             load;
  out_item_t        load_item;
  logic             is_last;

  assign out_free = !out_valid || !out_stall;
  assign is_last  = (CNT_W'(rd_idx) + CNT_W'(1) == cnt);

  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      frame_store[store_wr.idx] <= store_wr.data;
    end
    rd_data <= frame_store[rd_idx];
  end

  always_comb begin
    state_next              = state;
    rd_idx_next             = rd_idx;
    cnt_next                = cnt;
    q_pop                   = 1'b0;
    load                    = 1'b0;
    load_item.result_kind   = q_cmd.kind;
    load_item.frame_byte    = 8'd0;
    load_item.last          = 1'b1;
    back_status.stream_done = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.kind == KIND_BYTE) begin
            q_pop       = 1'b1;
            rd_idx_next = '0;
            cnt_next    = q_cmd.count;
            state_next  = BK_READ;
          end else if (out_free) begin
            q_pop = 1'b1;
            load  = 1'b1;
          end
        end
      end
      BK_READ: begin
        state_next = BK_SEND;
      end
      BK_SEND: begin
        if (out_free) begin
          load                  = 1'b1;
          load_item.result_kind = KIND_BYTE;
          load_item.frame_byte  = rd_data;
          load_item.last        = is_last;
          if (is_last) begin
            back_status.stream_done = 1'b1;
            state_next              = BK_IDLE;
          end else begin
            rd_idx_next = rd_idx + IDX_W'(1);
            state_next  = BK_READ;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      rd_idx    <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_idx <= rd_idx_next;
      cnt    <= cnt_next;
      if (out_free) begin
        out_valid <= load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      out_item <= load_item;
    end
  end

endmodule

FILE: rtl/stx_etx_frame_receiver_with_timeout_unit.sv
// Bus items: one per cycle into the deframer. Downlink and timeout results leave
// via the command queue and output register. Frame bytes are read, then sent.
// Input is stalled while the command queue is full or a frame stream is pending.
// Synchronous active-high reset: parser idle, no frame ready, timer clear,
// timeout register 10, queue and output empty. Frame store contents are not reset.
// Top level of the STX/ETX frame receiver with reply timeout.
module stx_etx_frame_receiver_with_timeout_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  stxrx_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output stxrx_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);
  import stxrx_pkg::*;

  logic         q_push;
  logic         q_pop;
  logic         q_full;
  logic         q_empty;
  cmd_t         push_cmd;
  cmd_t         pop_cmd;
  store_wr_t    store_wr;
  back_status_t back_status;

  assign cfg_ready = 1'b1;

  stxrx_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (push_cmd),
    .store_wr    (store_wr),
    .back_status (back_status)
  );

  stxrx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  stxrx_back u_back (
    .clk         (clk),
    .rst         (rst),
    .store_wr    (store_wr),
    .q_empty     (q_empty),
    .q_cmd       (pop_cmd),
    .q_pop       (q_pop),
    .back_status (back_status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

FILE: rtl/stxrx_checker.sv
// Port-level assertions for the frame receiver, bound to the top level.
module stxrx_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input stxrx_pkg::out_item_t out_item
);
  import stxrx_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_holds_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output transaction dropped while stalled");

  a_non_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.result_kind != KIND_BYTE |-> out_item.frame_byte == 8'd0)
    else $error("non-byte result carries a frame byte");

  a_non_byte_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.result_kind != KIND_BYTE |-> out_item.last)
    else $error("single result without last");

endmodule

bind stx_etx_frame_receiver_with_timeout_unit stxrx_checker u_stxrx_checker (.*);
